[rtl/fcs_pkg.sv]
package fcs_pkg;

    // one sensor sample
    typedef struct packed {
        logic [31:0] now_ms;
        logic        start_button;
        logic [15:0] stack_voltage_mv;
        logic [15:0] stack_current_ma;
        logic [15:0] cap_voltage_mv;
        logic        fault;
        logic        stop_request;
    } fcs_sample_t;

    // one controller result
    typedef struct packed {
        logic [2:0]  mode;
        logic        h2_valve_open;
        logic        purge_valve_open;
        logic        start_relay_closed;
        logic        res_relay_closed;
        logic        cap_relay_closed;
        logic        motor_relay_closed;
        logic [31:0] purge_count;
        logic [31:0] last_purge_interval_ms;
        logic [31:0] total_charge_c;
    } fcs_result_t;

    // operating modes
    localparam logic [2:0] MODE_STANDBY  = 3'd0;
    localparam logic [2:0] MODE_H2_FILL  = 3'd1;
    localparam logic [2:0] MODE_SPURGE   = 3'd2;
    localparam logic [2:0] MODE_CHARGE   = 3'd3;
    localparam logic [2:0] MODE_RUN      = 3'd4;
    localparam logic [2:0] MODE_SHUTDOWN = 3'd5;
    localparam logic [2:0] MODE_ALARM    = 3'd6;

    // purge phase
    localparam logic [1:0] PHASE_FIRST  = 2'd0;
    localparam logic [1:0] PHASE_CLOSED = 2'd1;
    localparam logic [1:0] PHASE_OPEN   = 2'd2;

    // relay and valve drive masks
    localparam logic [5:0] RV_H2    = 6'b000001;
    localparam logic [5:0] RV_PURGE = 6'b000010;
    localparam logic [5:0] RV_START = 6'b000100;
    localparam logic [5:0] RV_RES   = 6'b001000;
    localparam logic [5:0] RV_CAP   = 6'b010000;
    localparam logic [5:0] RV_MOTOR = 6'b100000;

    // configuration register indexes
    localparam int         REG_INDEX_W = 3;
    localparam logic [2:0] REG_PURGE_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_PURGE_DURATION  = 3'd1;
    localparam logic [2:0] REG_INTEG_INTERVAL  = 3'd2;
    localparam logic [2:0] REG_START_VOLTAGE   = 3'd3;
    localparam logic [2:0] REG_START_PURGE     = 3'd4;
    localparam logic [2:0] REG_CAP_CHARGED     = 3'd5;
    localparam logic [2:0] REG_CURRENT_OFFSET  = 3'd6;

    // configuration reset values
    localparam logic [63:0] RST_PURGE_THRESHOLD = 64'd2300000000;
    localparam logic [15:0] RST_PURGE_DURATION  = 16'd200;
    localparam logic [15:0] RST_INTEG_INTERVAL  = 16'd10;
    localparam logic [15:0] RST_START_VOLTAGE   = 16'd30000;
    localparam logic [15:0] RST_START_PURGE     = 16'd3000;
    localparam logic [15:0] RST_CAP_CHARGED     = 16'd40000;
    localparam logic [9:0]  RST_CURRENT_OFFSET  = 10'd100;

    // divide by 10^6 = 2^6 * 15625, long division in 16 bit digits
    localparam int          DIV_PRE_SHIFT   = 6;
    localparam int          DIV_CHUNK_W     = 16;
    localparam int          DIV_CHUNKS      = 4;
    localparam int          DIV_REM_W       = 14;
    localparam int          DIV_V_W         = DIV_REM_W + DIV_CHUNK_W;
    localparam int          DIV_RECIP_W     = 31;
    localparam int          DIV_PROD_W      = DIV_V_W + DIV_RECIP_W;
    localparam int          DIV_RECIP_SHIFT = 44;
    localparam logic [30:0] DIV_RECIP       = 31'd1125899907;
    localparam logic [13:0] DIV_ODD         = 14'd15625;
    localparam int          DIV_STAGES      = 2 * DIV_CHUNKS;

endpackage

[rtl/fcs_div1e6.sv]
module fcs_div1e6
    import fcs_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] dividend,
    output logic [31:0] quotient
);

    localparam int YW = 64 - DIV_PRE_SHIFT;

    // digit stage: quotient digit by reciprocal multiply
    logic [YW-1:0]          yq_reg [DIV_CHUNKS];
    logic [DIV_V_W-1:0]     v_reg  [DIV_CHUNKS];
    logic [DIV_CHUNK_W-1:0] qk_reg [DIV_CHUNKS];
    logic [31:0]            qa_reg [DIV_CHUNKS];
    // remainder stage
    logic [YW-1:0]          yr_reg [DIV_CHUNKS];
    logic [DIV_REM_W-1:0]   r_reg  [DIV_CHUNKS];
    logic [31:0]            qr_reg [DIV_CHUNKS];

    for (genvar k = 0; k < DIV_CHUNKS; k++) begin : g_chunk
        logic [YW-1:0]                     y_src;
        logic [DIV_REM_W-1:0]              r_src;
        logic [31:0]                       q_src;
        logic [DIV_CHUNK_W*DIV_CHUNKS-1:0] y_pad;
        logic [DIV_V_W-1:0]                v;
        logic [DIV_PROD_W-1:0]             prod;
        logic [DIV_V_W-1:0]                diff;

        if (k == 0) begin : g_first
            assign y_src = dividend[63:DIV_PRE_SHIFT];
            assign r_src = '0;
            assign q_src = '0;
        end
        else begin : g_next
            assign y_src = yr_reg[k-1];
            assign r_src = r_reg[k-1];
            assign q_src = qr_reg[k-1];
        end

        assign y_pad = {{(DIV_CHUNK_W*DIV_CHUNKS-YW){1'b0}}, y_src};
        assign v     = {r_src, y_pad[DIV_CHUNK_W*(DIV_CHUNKS-k)-1 -: DIV_CHUNK_W]};
        assign prod  = DIV_PROD_W'(v) * DIV_PROD_W'(DIV_RECIP);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[k]  <= v;
                qk_reg[k] <= prod[DIV_RECIP_SHIFT +: DIV_CHUNK_W];
                yq_reg[k] <= y_src;
                qa_reg[k] <= q_src;
            end
        end

        assign diff = v_reg[k] - DIV_V_W'(qk_reg[k]) * DIV_V_W'(DIV_ODD);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k]  <= diff[DIV_REM_W-1:0];
                yr_reg[k] <= yq_reg[k];
                qr_reg[k] <= {qa_reg[k][31-DIV_CHUNK_W:0], qk_reg[k]};
            end
        end
    end

    assign quotient = qr_reg[DIV_CHUNKS-1];

endmodule

[rtl/fuel_cell_startup_and_purge_sequencer.sv]
// fuel cell startup and purge sequencer
// sample channel: one sensor beat per tick (sample_valid / sample_stall), payload
//   fcs_sample_t; the beat is taken when sample_valid is high and sample_stall low
// result channel: one result beat per sample (result_valid / result_stall),
//   payload fcs_result_t, in sample order
// cfg channel: cfg_valid / cfg_ready with register index and 64 bit data; cfg_ready
//   is always high, writes are meant for idle periods only
// path: a sample beat is carried through the input register, the state update,
//   the 8 stage divide by 10^6 for the coulomb total and the output register
// throughput: one beat per cycle while no result is stalled; set by the state
//   update, where the charge slice multiply, 64 bit accumulate and threshold
//   compare close the loop from one sample to the next
// a stalled result freezes the whole pipeline, so sample_stall rises in the
//   same cycle; bubbles travel down the pipeline while nothing is stalled
// reset: configuration returns to its defaults, mode standby, all relays and
//   valves off, counters and charge sum cleared, no beats in flight
module fuel_cell_startup_and_purge_sequencer
    import fcs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   sample_valid,
    output logic                   sample_stall,
    input  fcs_sample_t            sample,
    output logic                   result_valid,
    input  logic                   result_stall,
    output fcs_result_t            result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [REG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]            cfg_data
);

    // record that rides along with the divider
    typedef struct packed {
        logic [2:0]  mode;
        logic [5:0]  rv;
        logic [31:0] purge_count;
        logic [31:0] interval;
        logic        purge;
    } fcs_track_t;

    // configuration
    logic [63:0] purge_threshold_reg;
    logic [15:0] purge_duration_reg;
    logic [15:0] integ_interval_reg;
    logic [15:0] start_voltage_reg;
    logic [15:0] start_purge_reg;
    logic [15:0] cap_charged_reg;
    logic [9:0]  current_offset_reg;

    // pipeline control
    logic        advance;
    logic        in_valid_reg;
    fcs_sample_t in_reg;
    logic        side_valid_reg [DIV_STAGES];
    fcs_track_t  track_reg      [DIV_STAGES];
    logic        result_valid_reg;
    fcs_track_t  out_track_reg;
    logic [31:0] div_q;

    // controller state
    logic [2:0]  mode_reg,         mode_next;
    logic [1:0]  phase_reg,        phase_next;
    logic [5:0]  rv_reg,           rv_next;
    logic [31:0] integ_start_reg,  integ_start_next;
    logic [31:0] purge_start_reg,  purge_start_next;
    logic [63:0] charge_sum_reg,   charge_sum_next;
    logic [31:0] since_purge_reg,  since_purge_next;
    logic [31:0] purge_count_reg,  purge_count_next;
    logic [31:0] last_interval_reg, last_interval_next;
    logic [31:0] total_charge_reg;

    // integration datapath
    logic [2:0]  mode_eff;
    logic        charge_first;
    logic [31:0] integ_base;
    logic [31:0] elapsed_int;
    logic [16:0] slice_current;
    logic        do_int;
    logic [48:0] slice;
    logic [64:0] sum_wide;
    logic [63:0] sum_int;
    logic [31:0] since_int;
    logic [31:0] integ_after;
    logic [31:0] spurge_start;
    logic        purge_hit;
    fcs_track_t  core_track;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            purge_threshold_reg <= RST_PURGE_THRESHOLD;
            purge_duration_reg  <= RST_PURGE_DURATION;
            integ_interval_reg  <= RST_INTEG_INTERVAL;
            start_voltage_reg   <= RST_START_VOLTAGE;
            start_purge_reg     <= RST_START_PURGE;
            cap_charged_reg     <= RST_CAP_CHARGED;
            current_offset_reg  <= RST_CURRENT_OFFSET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PURGE_THRESHOLD: purge_threshold_reg <= cfg_data;
                REG_PURGE_DURATION:  purge_duration_reg  <= cfg_data[15:0];
                REG_INTEG_INTERVAL:  integ_interval_reg  <= cfg_data[15:0];
                REG_START_VOLTAGE:   start_voltage_reg   <= cfg_data[15:0];
                REG_START_PURGE:     start_purge_reg     <= cfg_data[15:0];
                REG_CAP_CHARGED:     cap_charged_reg     <= cfg_data[15:0];
                REG_CURRENT_OFFSET:  current_offset_reg  <= cfg_data[9:0];
                default:             ;
            endcase
        end
    end

    // whole pipeline moves unless the result beat is held
    assign advance      = !(result_valid_reg && result_stall);
    assign sample_stall = !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (advance)
            in_valid_reg <= sample_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && sample_valid)
            in_reg <= sample;
    end

    // fault beats stop, alarm is never left
    always_comb
    begin
        mode_eff = mode_reg;
        if (in_reg.fault)
            mode_eff = MODE_ALARM;
        else if (in_reg.stop_request && mode_reg != MODE_ALARM)
            mode_eff = MODE_SHUTDOWN;
    end

    // charge slice: elapsed ms times current, saturating sum
    assign charge_first  = (mode_eff == MODE_CHARGE) && (phase_reg == PHASE_FIRST);
    assign integ_base    = charge_first ? in_reg.now_ms : integ_start_reg;
    assign elapsed_int   = in_reg.now_ms - integ_base;
    assign slice_current = (mode_eff == MODE_CHARGE)
                         ? 17'(in_reg.stack_current_ma) + 17'(current_offset_reg)
                         : 17'(in_reg.stack_current_ma);
    assign do_int        = ((mode_eff == MODE_CHARGE) || (mode_eff == MODE_RUN))
                         && (elapsed_int > 32'(integ_interval_reg));
    assign slice         = 49'(elapsed_int) * 49'(slice_current);
    assign sum_wide      = {1'b0, charge_sum_reg} + 65'(slice);
    assign sum_int       = !do_int      ? charge_sum_reg
                         : sum_wide[64] ? '1
                         :                sum_wide[63:0];
    assign since_int     = do_int ? since_purge_reg + elapsed_int : since_purge_reg;
    assign integ_after   = do_int ? in_reg.now_ms : integ_base;
    assign spurge_start  = ((rv_reg & RV_PURGE) == '0) ? in_reg.now_ms : purge_start_reg;
    assign purge_hit     = (mode_eff == MODE_RUN) && (sum_int > purge_threshold_reg);

    always_comb
    begin
        mode_next          = mode_eff;
        phase_next         = phase_reg;
        rv_next            = rv_reg;
        integ_start_next   = integ_start_reg;
        purge_start_next   = purge_start_reg;
        charge_sum_next    = charge_sum_reg;
        since_purge_next   = since_purge_reg;
        purge_count_next   = purge_count_reg;
        last_interval_next = last_interval_reg;

        unique case (mode_eff)
            MODE_STANDBY:
            begin
                if (in_reg.start_button)
                    mode_next = MODE_H2_FILL;
                else
                    rv_next = '0;
            end
            MODE_H2_FILL:
            begin
                rv_next = RV_H2;
                if (in_reg.stack_voltage_mv >= start_voltage_reg)
                    mode_next = MODE_SPURGE;
            end
            MODE_SPURGE:
            begin
                purge_start_next = spurge_start;
                if ((in_reg.now_ms - spurge_start) >= 32'(start_purge_reg))
                begin
                    rv_next   = RV_H2;
                    mode_next = MODE_CHARGE;
                end
                else
                    rv_next = RV_H2 | RV_START | RV_PURGE;
            end
            MODE_CHARGE:
            begin
                if (charge_first)
                    phase_next = PHASE_CLOSED;
                integ_start_next = integ_after;
                charge_sum_next  = sum_int;
                since_purge_next = since_int;
                // precharge, then resistor off, capacitor on, motor on
                if (in_reg.cap_voltage_mv < cap_charged_reg)
                    rv_next = RV_H2 | RV_RES;
                else if ((rv_reg & RV_RES) != '0)
                    rv_next = rv_reg & ~RV_RES;
                else if ((rv_reg & RV_CAP) == '0)
                    rv_next = rv_reg | RV_CAP;
                else
                begin
                    rv_next   = (rv_reg & ~RV_PURGE) | RV_MOTOR | RV_H2;
                    mode_next = MODE_RUN;
                end
            end
            MODE_RUN:
            begin
                integ_start_next = integ_after;
                charge_sum_next  = sum_int;
                since_purge_next = since_int;
                if (purge_hit)
                begin
                    rv_next            = rv_reg | RV_PURGE;
                    purge_count_next   = purge_count_reg + 32'd1;
                    charge_sum_next    = '0;
                    last_interval_next = since_int;
                    since_purge_next   = '0;
                    integ_start_next   = in_reg.now_ms;
                    purge_start_next   = in_reg.now_ms;
                    phase_next         = PHASE_OPEN;
                end
                // a purge started this tick has zero elapsed time
                else if (phase_reg == PHASE_OPEN
                         && (in_reg.now_ms - purge_start_reg) > 32'(purge_duration_reg))
                begin
                    rv_next    = rv_reg & ~RV_PURGE;
                    phase_next = PHASE_CLOSED;
                end
            end
            default:
            begin
                // shutdown and alarm: valves, motor and startup relay off
                rv_next = rv_reg & ~(RV_H2 | RV_PURGE | RV_MOTOR | RV_START);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_STANDBY;
            phase_reg         <= PHASE_FIRST;
            rv_reg            <= '0;
            integ_start_reg   <= '0;
            purge_start_reg   <= '0;
            charge_sum_reg    <= '0;
            since_purge_reg   <= '0;
            purge_count_reg   <= '0;
            last_interval_reg <= '0;
        end
        else if (advance && in_valid_reg)
        begin
            mode_reg          <= mode_next;
            phase_reg         <= phase_next;
            rv_reg            <= rv_next;
            integ_start_reg   <= integ_start_next;
            purge_start_reg   <= purge_start_next;
            charge_sum_reg    <= charge_sum_next;
            since_purge_reg   <= since_purge_next;
            purge_count_reg   <= purge_count_next;
            last_interval_reg <= last_interval_next;
        end
    end

    assign core_track = '{
        mode:        mode_next,
        rv:          rv_next,
        purge_count: purge_count_next,
        interval:    last_interval_next,
        purge:       purge_hit
    };

    // coulombs from the pre-purge sum, aligned with the track pipeline
    fcs_div1e6 u_div (
        .clk      (clk),
        .en       (advance),
        .dividend (sum_int),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_STAGES; i++)
                side_valid_reg[i] <= 1'b0;
        end
        else if (advance)
        begin
            side_valid_reg[0] <= in_valid_reg;
            for (int i = 1; i < DIV_STAGES; i++)
                side_valid_reg[i] <= side_valid_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            track_reg[0] <= core_track;
            for (int i = 1; i < DIV_STAGES; i++)
                track_reg[i] <= track_reg[i-1];
        end
    end

    // output stage, coulomb total kept here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            total_charge_reg <= '0;
        end
        else if (advance)
        begin
            result_valid_reg <= side_valid_reg[DIV_STAGES-1];
            if (side_valid_reg[DIV_STAGES-1] && track_reg[DIV_STAGES-1].purge)
                total_charge_reg <= total_charge_reg + div_q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && side_valid_reg[DIV_STAGES-1])
            out_track_reg <= track_reg[DIV_STAGES-1];
    end

    assign result_valid                  = result_valid_reg;
    assign result.mode                   = out_track_reg.mode;
    assign result.h2_valve_open          = |(out_track_reg.rv & RV_H2);
    assign result.purge_valve_open       = |(out_track_reg.rv & RV_PURGE);
    assign result.start_relay_closed     = |(out_track_reg.rv & RV_START);
    assign result.res_relay_closed       = |(out_track_reg.rv & RV_RES);
    assign result.cap_relay_closed       = |(out_track_reg.rv & RV_CAP);
    assign result.motor_relay_closed     = |(out_track_reg.rv & RV_MOTOR);
    assign result.purge_count            = out_track_reg.purge_count;
    assign result.last_purge_interval_ms = out_track_reg.interval;
    assign result.total_charge_c         = total_charge_reg;

endmodule

[rtl/fcs_checker.sv]
module fcs_checker
    import fcs_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   sample_valid,
    input logic                   sample_stall,
    input fcs_sample_t            sample,
    input logic                   result_valid,
    input logic                   result_stall,
    input fcs_result_t            result,
    input logic                   cfg_valid,
    input logic                   cfg_ready,
    input logic [REG_INDEX_W-1:0] cfg_index,
    input logic [63:0]            cfg_data
);

    // held result beat stays put
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    // alarm is latched across beats
    a_alarm_latch: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.mode == MODE_ALARM |=> result.mode == MODE_ALARM)
        else $error("alarm mode left");

    // safe state drives
    a_safe_off: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.mode == MODE_ALARM || result.mode == MODE_SHUTDOWN)
        |-> !result.h2_valve_open && !result.purge_valve_open
            && !result.start_relay_closed && !result.motor_relay_closed)
        else $error("valve or relay on in shutdown or alarm");

    a_standby_off: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.mode == MODE_STANDBY
        |-> !result.h2_valve_open && !result.purge_valve_open
            && !result.start_relay_closed && !result.res_relay_closed
            && !result.cap_relay_closed && !result.motor_relay_closed)
        else $error("drive on in standby");

    a_run_relays: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.mode == MODE_RUN
        |-> result.motor_relay_closed && result.cap_relay_closed
            && result.h2_valve_open && !result.res_relay_closed
            && !result.start_relay_closed)
        else $error("wrong relay set in run");

endmodule

bind fuel_cell_startup_and_purge_sequencer fcs_checker u_fcs_checker (.*);
